@@ src/spsm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spsm_pkg
// shared types and constants of the servo pulse slew mapper
// ----------------------------------------------------------------------------
package spsm_pkg;

   localparam int DivBits = 36;

   // item kinds
   typedef enum logic [1:0] {
      KIND_SET_VALUE  = 2'd0,
      KIND_SET_TARGET = 2'd1,
      KIND_TICK       = 2'd2,
      KIND_NONE       = 2'd3
   } kind_type;

   // register indexes
   localparam logic [2:0] REG_SERVO_TYPE    = 3'd0;
   localparam logic [2:0] REG_SMOOTH_MODE   = 3'd1;
   localparam logic [2:0] REG_VALUE_MIN     = 3'd2;
   localparam logic [2:0] REG_VALUE_MAX     = 3'd3;
   localparam logic [2:0] REG_PULSE_MIN     = 3'd4;
   localparam logic [2:0] REG_PULSE_MID     = 3'd5;
   localparam logic [2:0] REG_PULSE_MAX     = 3'd6;
   localparam logic [2:0] REG_COMPARE_SCALE = 3'd7;

   // front to back command: value to emit
   typedef struct packed {
      logic signed [15:0] cur;
   } cmd_type;

   // configuration seen by the back end
   typedef struct packed {
      logic               servo_type;
      logic signed [15:0] value_min;
      logic signed [15:0] value_max;
      logic [12:0]        pulse_min;
      logic [12:0]        pulse_mid;
      logic [12:0]        pulse_max;
      logic [21:0]        compare_scale;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_MUL, BK_DIV, BK_SCALE, BK_CMP, BK_OUT
   } bk_state_type;

endpackage
`default_nettype wire

@@ src/spsm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spsm_front
// accepts items, keeps the ramp state and queues values to be mapped
// ----------------------------------------------------------------------------
module spsm_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire  [1:0]             req_kind,
   input  wire  signed [15:0]     req_value,
   input  wire  [13:0]            req_step,
   input  wire                    smooth_mode,
   input  wire  signed [15:0]     value_min,
   input  wire  signed [15:0]     value_max,
   output logic                   cmd_valid,
   output spsm_pkg::cmd_type      cmd_data,
   input  wire                    cmd_take
);
   import spsm_pkg::*;

   logic signed [15:0] cur_ff, cur_in, tgt_ff, tgt_in;
   logic [13:0]        step_ff, step_in;
   cmd_type            q_ff [2];
   logic               wp_ff, rp_ff;
   logic [1:0]         cnt_ff;
   logic               acc, push;
   logic signed [16:0] delta, up, dn;
   logic signed [15:0] clamped;

   assign req_stall = (cnt_ff == 2'd2);
   assign acc       = req_valid && !req_stall;

   // clamp up to min then down to max
   always_comb begin
      clamped = (req_value < value_min) ? value_min : req_value;
      if (clamped > value_max) clamped = value_max;
   end

   // state update
   always_comb begin
      cur_in  = cur_ff;
      tgt_in  = tgt_ff;
      step_in = step_ff;
      push    = 1'b0;
      delta   = 17'(tgt_ff) - 17'(cur_ff);
      up      = 17'(cur_ff) + 17'(signed'({1'b0, step_ff}));
      dn      = 17'(cur_ff) - 17'(signed'({1'b0, step_ff}));
      if (acc) begin
         case (kind_type'(req_kind))
            KIND_SET_VALUE: begin
               cur_in = req_value;
               push   = 1'b1;
            end
            KIND_SET_TARGET: begin
               tgt_in  = clamped;
               step_in = req_step;
            end
            KIND_TICK: begin
               if (smooth_mode) begin
                  push = 1'b1;
                  if (delta > -17'sd10 && delta < 17'sd10) cur_in = tgt_ff;
                  else if (delta > 0) cur_in = (up > 17'(tgt_ff)) ? tgt_ff : up[15:0];
                  else cur_in = (dn < 17'(tgt_ff)) ? tgt_ff : dn[15:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // two entry queue
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0; tgt_ff <= '0; step_ff <= '0;
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         cur_ff <= cur_in; tgt_ff <= tgt_in; step_ff <= step_in;
         if (push) wp_ff <= !wp_ff;
         if (cmd_take) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(cmd_take);
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= '{cur: cur_in};
   end

   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rp_ff];

`ifndef SYNTHESIS
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_take: assert property (@(posedge clock) disable iff (reset) cmd_take |-> cmd_valid)
      else $error("take from empty queue");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !cmd_take) |=> cnt_ff == 2'd2)
      else $error("full queue lost entry");
`endif
endmodule
`default_nettype wire

@@ src/spsm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spsm_back
// maps a value to pulse width and compare with a serial divider
// ----------------------------------------------------------------------------
module spsm_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 cmd_valid,
   input  spsm_pkg::cmd_type   cmd_data,
   output logic                cmd_take,
   input  spsm_pkg::cfg_type   cfg,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [15:0]         rsp_compare,
   output logic [12:0]         rsp_pulse_us,
   output logic signed [15:0]  rsp_current_value
);
   import spsm_pkg::*;

   bk_state_type       st_ff, st_in;
   logic signed [15:0] cur_ff;
   logic signed [17:0] a_ff;      // multiplicand
   logic signed [17:0] b_ff;      // multiplier
   logic signed [17:0] base_ff;   // base pulse
   logic               neg_ff, zero_ff;
   logic [16:0]        den_ff;
   logic [DivBits-1:0] num_ff, quo_ff;
   logic [DivBits:0]   rem_ff;
   logic [5:0]         cnt_ff;
   logic [12:0]        pulse_ff;
   logic [34:0]        cmpw_ff;
   logic [15:0]        cmp_sat;
   logic               cmp_ovf;
   logic signed [15:0] v;
   logic signed [35:0] prod;
   logic [DivBits:0]   rtry;
   logic signed [19:0] pfull;

   always_comb begin
      v = (cmd_data.cur < cfg.value_min) ? cfg.value_min : cmd_data.cur;
      if (v > cfg.value_max) v = cfg.value_max;
   end

   assign prod  = a_ff * b_ff;
   assign rtry  = {rem_ff[DivBits-1:0], num_ff[DivBits-1]};
   assign pfull = neg_ff ? 20'(base_ff) - 20'(signed'({1'b0, quo_ff[17:0]}))
                         : 20'(base_ff) + 20'(signed'({1'b0, quo_ff[17:0]}));
   assign cmd_take = (st_ff == BK_IDLE) && cmd_valid;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_IDLE:  if (cmd_valid) st_in = BK_MUL;
         BK_MUL:   st_in = zero_ff ? BK_SCALE : BK_DIV;
         BK_DIV:   if (cnt_ff == 6'(DivBits - 1)) st_in = BK_SCALE;
         BK_SCALE: st_in = BK_CMP;
         BK_CMP:   st_in = BK_OUT;
         BK_OUT:   if (!rsp_stall) st_in = BK_IDLE;
         default:  st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= BK_IDLE;
      else st_ff <= st_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      case (st_ff)
         BK_IDLE: if (cmd_valid) begin
            cur_ff  <= cmd_data.cur;
            zero_ff <= 1'b0;
            if (!cfg.servo_type) begin
               a_ff    <= 18'(v) - 18'(cfg.value_min);
               b_ff    <= 18'({1'b0, cfg.pulse_max}) - 18'({1'b0, cfg.pulse_min});
               base_ff <= 18'({1'b0, cfg.pulse_min});
               if (cfg.value_max >= cfg.value_min)
                  den_ff <= 17'(18'(cfg.value_max) - 18'(cfg.value_min));
               else
                  den_ff <= 17'(18'(cfg.value_min) - 18'(cfg.value_max));
               zero_ff <= (cfg.value_max == cfg.value_min);
               neg_ff  <= (cfg.value_max < cfg.value_min);
            end else begin
               base_ff <= 18'({1'b0, cfg.pulse_mid});
               den_ff  <= 17'd10000;
               neg_ff  <= 1'b0;
               zero_ff <= (v == 0);
               if (v > 0) begin
                  a_ff <= 18'(v);
                  b_ff <= 18'({1'b0, cfg.pulse_max}) - 18'({1'b0, cfg.pulse_mid});
               end else begin
                  a_ff <= -18'(v);
                  b_ff <= 18'({1'b0, cfg.pulse_mid}) - 18'({1'b0, cfg.pulse_min});
                  neg_ff <= 1'b1;
               end
            end
         end
         BK_MUL: begin
            // fold sign of product into neg, add half divisor
            neg_ff <= neg_ff ^ prod[35];
            num_ff <= (prod[35] ? DivBits'(-prod) : DivBits'(prod))
                      + DivBits'(den_ff[16:1]);
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= '0;
            if (zero_ff) begin
               quo_ff <= '0;
               neg_ff <= 1'b0;
            end
         end
         BK_DIV: begin
            // restoring division, one bit a cycle
            num_ff <= {num_ff[DivBits-2:0], 1'b0};
            cnt_ff <= cnt_ff + 6'd1;
            if (rtry >= (DivBits+1)'(den_ff)) begin
               rem_ff <= rtry - (DivBits+1)'(den_ff);
               quo_ff <= {quo_ff[DivBits-2:0], 1'b1};
            end else begin
               rem_ff <= rtry;
               quo_ff <= {quo_ff[DivBits-2:0], 1'b0};
            end
         end
         BK_SCALE: begin
            if (quo_ff[DivBits-1:18] != '0 || pfull > 20'sd8191) pulse_ff <= 13'd8191;
            else if (pfull < 0) pulse_ff <= 13'd0;
            else pulse_ff <= pfull[12:0];
         end
         BK_OUT: begin
         end
         default: begin
         end
      endcase
   end

   // compare product registered after pulse settles
   always_ff @(posedge clock) begin
      cmpw_ff <= pulse_ff * cfg.compare_scale;
   end

   always_comb begin
      cmp_ovf = (cmpw_ff[34:32] != 3'd0);
      cmp_sat = cmp_ovf ? 16'hffff : cmpw_ff[31:16];
   end

   // outputs
   always_comb begin
      rsp_valid         = (st_ff == BK_OUT);
      rsp_compare       = cmp_sat;
      rsp_pulse_us      = pulse_ff;
      rsp_current_value = cur_ff;
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped");
   a_take: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> st_ff == BK_MUL)
      else $error("take without start");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      st_ff == BK_DIV |-> cnt_ff < 6'(DivBits))
      else $error("divider overrun");
`endif
endmodule
`default_nettype wire

@@ src/servo_pulse_slew_mapper.sv @@
`default_nettype none
// an item with a result passes the queue, then the back end states: multiply, 36 divider steps, scale, compare, output
// a zero span, or a zero value in continuous mode, skips the divider
// the back end takes a new value only after its last result is delivered, as the serial divider is busy in between
// items without result are taken while the two entry queue has room
// reset: synchronous, clears ramp state, queue and registers to defaults
// ----------------------------------------------------------------------------
// servo_pulse_slew_mapper
// rc servo pulse and compare generator with slew limited ramp
// ----------------------------------------------------------------------------
module servo_pulse_slew_mapper (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [1:0]         req_kind,
   input  wire  signed [15:0] req_value,
   input  wire  [13:0]        req_step,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [15:0]        rsp_compare,
   output logic [12:0]        rsp_pulse_us,
   output logic signed [15:0] rsp_current_value,
   input  wire                csr_write,
   input  wire  [2:0]         csr_index,
   input  wire  [21:0]        csr_data
);
   import spsm_pkg::*;

   cfg_type cfg_ff;
   logic    smooth_ff;
   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '{servo_type: 1'b0, value_min: 16'sd0, value_max: 16'sd18000,
                        pulse_min: 13'd500, pulse_mid: 13'd1500, pulse_max: 13'd2500,
                        compare_scale: 22'd65536};
         smooth_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_SERVO_TYPE:    cfg_ff.servo_type    <= csr_data[0];
            REG_SMOOTH_MODE:   smooth_ff            <= csr_data[0];
            REG_VALUE_MIN:     cfg_ff.value_min     <= csr_data[15:0];
            REG_VALUE_MAX:     cfg_ff.value_max     <= csr_data[15:0];
            REG_PULSE_MIN:     cfg_ff.pulse_min     <= csr_data[12:0];
            REG_PULSE_MID:     cfg_ff.pulse_mid     <= csr_data[12:0];
            REG_PULSE_MAX:     cfg_ff.pulse_max     <= csr_data[12:0];
            REG_COMPARE_SCALE: cfg_ff.compare_scale <= csr_data;
            default: begin
            end
         endcase
      end
   end

   spsm_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_value, .req_step,
      .smooth_mode(smooth_ff), .value_min(cfg_ff.value_min),
      .value_max(cfg_ff.value_max), .cmd_valid, .cmd_data, .cmd_take
   );

   spsm_back u_back (
      .clock, .reset, .cmd_valid, .cmd_data, .cmd_take, .cfg(cfg_ff),
      .rsp_valid, .rsp_stall, .rsp_compare, .rsp_pulse_us, .rsp_current_value
   );
endmodule
`default_nettype wire

@@ verif/servo_pulse_slew_mapper_tb.sv @@
// ----------------------------------------------------------------------------
// servo_pulse_slew_mapper_tb
// drives set value, set target, tick and none items into the servo mapper under
// several register settings and compares every result against a local
// bit accurate predictor of pulse width, compare value and current value
// ----------------------------------------------------------------------------
module servo_pulse_slew_mapper_tb;
   import spsm_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_kind;
   logic signed [15:0] req_value;
   logic [13:0]        req_step;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [15:0]        rsp_compare;
   logic [12:0]        rsp_pulse_us;
   logic signed [15:0] rsp_current_value;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [21:0]        csr_data;

   typedef struct packed {
      logic [15:0]        compare;
      logic [12:0]        pulse_us;
      logic signed [15:0] current_value;
   } servo_out_type;

   servo_out_type pending_outs[$];

   // predictor copy of registers and ramp state
   logic               m_type;
   logic               m_smooth;
   logic signed [15:0] m_vmin;
   logic signed [15:0] m_vmax;
   logic [12:0]        m_pmin;
   logic [12:0]        m_pmid;
   logic [12:0]        m_pmax;
   logic [21:0]        m_scale;
   logic signed [15:0] m_cur;
   logic signed [15:0] m_target;
   logic [13:0]        m_ramp;

   int errors;
   int sent_items;
   int checked_outs;
   longint cycles;
   bit stall_free;

   servo_pulse_slew_mapper dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_value(req_value), .req_step(req_step),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_compare(rsp_compare),
      .rsp_pulse_us(rsp_pulse_us), .rsp_current_value(rsp_current_value),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("timeout at %0t", $time);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic longint round_div(longint num, longint den);
      if (num < 0) return -((-num + den / 2) / den);
      return (num + den / 2) / den;
   endfunction

   function automatic longint clamp_to_limits(longint v);
      if (v < m_vmin) v = m_vmin;
      if (v > m_vmax) v = m_vmax;
      return v;
   endfunction

   // pulse width and compare for the current value
   function automatic servo_out_type servo_output();
      servo_out_type o;
      longint v, span, num, p, cmp;
      v = clamp_to_limits(m_cur);
      if (m_type == 1'b0) begin
         span = longint'(m_vmax) - longint'(m_vmin);
         num = (v - m_vmin) * (longint'(m_pmax) - longint'(m_pmin));
         if (span == 0) p = m_pmin;
         else begin
            if (span < 0) begin
               span = -span;
               num = -num;
            end
            p = m_pmin + round_div(num, span);
         end
      end else if (v == 0) p = m_pmid;
      else if (v > 0) p = m_pmid + round_div(v * (longint'(m_pmax) - m_pmid), 10000);
      else p = m_pmid - round_div(-v * (longint'(m_pmid) - m_pmin), 10000);
      if (p < 0) p = 0;
      if (p > 8191) p = 8191;
      cmp = (p * longint'(m_scale)) >>> 16;
      if (cmp > 65535) cmp = 65535;
      o.compare = cmp[15:0];
      o.pulse_us = p[12:0];
      o.current_value = m_cur;
      return o;
   endfunction

   // advance the predictor by one item
   task automatic predict_servo(logic [1:0] kind, logic signed [15:0] value,
                                logic [13:0] step);
      longint delta, c;
      case (kind)
         KIND_SET_VALUE: begin
            m_cur = value;
            pending_outs.push_back(servo_output());
         end
         KIND_SET_TARGET: begin
            m_target = 16'(clamp_to_limits(value));
            m_ramp = step;
         end
         KIND_TICK: if (m_smooth) begin
            delta = longint'(m_target) - longint'(m_cur);
            c = m_cur;
            if (delta > -10 && delta < 10) c = m_target;
            else if (delta > 0) begin
               c = c + m_ramp;
               if (c > m_target) c = m_target;
            end else begin
               c = c - m_ramp;
               if (c < m_target) c = m_target;
            end
            m_cur = 16'(c);
            pending_outs.push_back(servo_output());
         end
         default: ;
      endcase
   endtask

   // send one item, idling at random first; valid drops at the next idle or drain
   task automatic send_item(logic [1:0] kind, logic signed [15:0] value,
                            logic [13:0] step);
      @(negedge clock);
      while (!stall_free && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value <= value;
      req_step <= step;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_servo(kind, value, step);
      sent_items++;
   endtask

   // wait for all results, then a latency pause
   task automatic drain_outs();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outs.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   // write one register; the caller drops the write enable after the last one
   task automatic write_reg(logic [2:0] index, logic [21:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(negedge clock);
      case (index)
         REG_SERVO_TYPE:    m_type = data[0];
         REG_SMOOTH_MODE:   m_smooth = data[0];
         REG_VALUE_MIN:     m_vmin = data[15:0];
         REG_VALUE_MAX:     m_vmax = data[15:0];
         REG_PULSE_MIN:     m_pmin = data[12:0];
         REG_PULSE_MID:     m_pmid = data[12:0];
         REG_PULSE_MAX:     m_pmax = data[12:0];
         REG_COMPARE_SCALE: m_scale = data;
         default: ;
      endcase
   endtask

   task automatic set_all(logic typ, logic smooth, int vmin, int vmax, int pmin,
                          int pmid, int pmax, int scale);
      drain_outs();
      write_reg(REG_SERVO_TYPE, 22'(typ));
      write_reg(REG_SMOOTH_MODE, 22'(smooth));
      write_reg(REG_VALUE_MIN, 22'(16'(vmin)));
      write_reg(REG_VALUE_MAX, 22'(16'(vmax)));
      write_reg(REG_PULSE_MIN, 22'(pmin));
      write_reg(REG_PULSE_MID, 22'(pmid));
      write_reg(REG_PULSE_MAX, 22'(pmax));
      write_reg(REG_COMPARE_SCALE, 22'(scale));
      csr_write <= 1'b0;
   endtask

   function automatic logic signed [15:0] rand_value();
      if ($urandom_range(9) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(40000)) - 20000);
   endfunction

   // directed extremes and special cases, first under reset settings, then under others
   task automatic test_directed();
      send_item(KIND_SET_VALUE, 16'sd0, 14'd0);
      send_item(KIND_SET_VALUE, 16'sd18000, 14'd0);
      send_item(KIND_SET_VALUE, 16'sd32767, 14'h3fff);
      send_item(KIND_SET_VALUE, -16'sd32768, 14'd0);
      send_item(KIND_SET_VALUE, 16'sd9001, 14'd0);
      send_item(KIND_TICK, 16'sd0, 14'd0);
      send_item(KIND_NONE, 16'sd5, 14'd5);
      send_item(KIND_SET_TARGET, 16'sd30000, 14'd10000);
      set_all(1'b0, 1'b1, -20000, 20000, 0, 2500, 5000, 4194303);
      send_item(KIND_SET_VALUE, -16'sd20000, 14'd0);
      send_item(KIND_SET_TARGET, 16'sd20000, 14'h3fff);
      send_item(KIND_TICK, 16'sd0, 14'd0);
      send_item(KIND_SET_TARGET, 16'sd19995, 14'd3);
      send_item(KIND_TICK, 16'sd0, 14'd0);
      send_item(KIND_SET_TARGET, -16'sd100, 14'd0);
      send_item(KIND_TICK, 16'sd0, 14'd0);
      send_item(KIND_SET_TARGET, 16'sd0, 14'd7000);
      send_item(KIND_TICK, 16'sd0, 14'd0);
      send_item(KIND_TICK, 16'sd0, 14'd0);
      // zero span and inverted limits
      set_all(1'b0, 1'b0, 500, 500, 8191, 0, 0, 65536);
      send_item(KIND_SET_VALUE, 16'sd500, 14'd0);
      set_all(1'b0, 1'b0, 1000, -1000, 100, 0, 5000, 65536);
      send_item(KIND_SET_VALUE, 16'sd0, 14'd0);
      // continuous mode both directions
      set_all(1'b1, 1'b0, -20000, 20000, 8191, 0, 8191, 0);
      send_item(KIND_SET_VALUE, 16'sd20000, 14'd0);
      send_item(KIND_SET_VALUE, -16'sd20000, 14'd0);
      send_item(KIND_SET_VALUE, 16'sd0, 14'd0);
   endtask

   // random ramps under random settings
   task automatic test_random_phase(int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         if (k < 15) send_item(KIND_SET_VALUE, rand_value(), 14'($urandom));
         else if (k < 30) send_item(KIND_SET_TARGET, rand_value(),
                                    $urandom_range(3) == 0 ? 14'($urandom)
                                                           : 14'($urandom_range(3000)));
         else if (k < 95) send_item(KIND_TICK, rand_value(), 14'($urandom));
         else send_item(KIND_NONE, rand_value(), 14'($urandom));
      end
   endtask

   task automatic test_random();
      int lo, hi;
      for (int ph = 0; ph < 8; ph++) begin
         lo = $signed($urandom_range(40000)) - 20000;
         hi = $signed($urandom_range(40000)) - 20000;
         if (ph % 4 != 3 && lo > hi) begin
            int t;
            t = lo;
            lo = hi;
            hi = t;
         end
         stall_free = (ph == 5);
         set_all(1'($urandom), ph != 6, lo, hi, $urandom_range(5000),
                 $urandom_range(5000), $urandom_range(5000),
                 ph == 2 ? 4194303 : $urandom_range(4194303) >> $urandom_range(7));
         test_random_phase(55);
      end
      stall_free = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      servo_out_type exp_o;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outs.size() == 0) begin
            $display("%0t unexpected result cmp %0d pulse %0d cur %0d", $time,
                     rsp_compare, rsp_pulse_us, rsp_current_value);
            errors++;
         end else begin
            exp_o = pending_outs.pop_front();
            checked_outs++;
            if (rsp_compare !== exp_o.compare) begin
               $display("%0t compare exp %0d got %0d", $time, exp_o.compare, rsp_compare);
               errors++;
            end
            if (rsp_pulse_us !== exp_o.pulse_us) begin
               $display("%0t pulse_us exp %0d got %0d", $time, exp_o.pulse_us,
                        rsp_pulse_us);
               errors++;
            end
            if (rsp_current_value !== exp_o.current_value) begin
               $display("%0t current_value exp %0d got %0d", $time,
                        exp_o.current_value, rsp_current_value);
               errors++;
            end
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      rsp_stall <= !stall_free && ($urandom_range(99) < 31);
   end

   initial begin
      errors = 0;
      sent_items = 0;
      checked_outs = 0;
      cycles = 0;
      stall_free = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_SET_VALUE;
      req_value = '0;
      req_step = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = REG_SERVO_TYPE;
      csr_data = '0;
      m_type = 1'b0;
      m_smooth = 1'b0;
      m_vmin = 16'sd0;
      m_vmax = 16'sd18000;
      m_pmin = 13'd500;
      m_pmid = 13'd1500;
      m_pmax = 13'd2500;
      m_scale = 22'd65536;
      m_cur = '0;
      m_target = '0;
      m_ramp = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random();
      drain_outs();
      $display("sent %0d items over angle and continuous settings, checked %0d results",
               sent_items, checked_outs);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

@@ sim.f @@
src/spsm_pkg.sv
src/spsm_front.sv
src/spsm_back.sv
src/servo_pulse_slew_mapper.sv
verif/servo_pulse_slew_mapper_tb.sv
